FILE: src/psg_tone_noise_generator_macros.svh
// Assertion macros for the programmable sound generator.
// Used by the channel and mixer modules; no other dependencies.
`ifndef PSG_TONE_NOISE_GENERATOR_MACROS_SVH
`define PSG_TONE_NOISE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PSG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("psg assertion failed");
`define PSG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("psg assertion failed");
`else
`define PSG_ASSERT(label, clk, rst, prop)
`define PSG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/psg_pkg.sv
// Shared types, constants and lookup functions for the sound generator.
// No dependencies.
`default_nettype none
package psg_pkg;

   localparam int NUM_TONE = 3;
   localparam int NUM_CHAN = 4;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [2:0] CSR_PAN_TONE0     = 3'd0;
   localparam logic [2:0] CSR_PAN_TONE1     = 3'd1;
   localparam logic [2:0] CSR_PAN_TONE2     = 3'd2;
   localparam logic [2:0] CSR_PAN_NOISE     = 3'd3;
   localparam logic [2:0] CSR_MASTER_VOLUME = 3'd4;

   localparam logic [6:0] PAN_TONE0_RESET  = 7'd20;
   localparam logic [6:0] PAN_TONE1_RESET  = 7'd80;
   localparam logic [6:0] PAN_TONE2_RESET  = 7'd50;
   localparam logic [6:0] PAN_NOISE_RESET  = 7'd50;
   localparam logic [6:0] VOLUME_RESET     = 7'd100;
   localparam logic [6:0] PCT_MAX          = 7'd100;

   localparam logic [1:0]  NOISE_CHAN       = 2'd3;
   localparam logic [1:0]  NOISE_RATE_16    = 2'd0;
   localparam logic [1:0]  NOISE_RATE_32    = 2'd1;
   localparam logic [1:0]  NOISE_RATE_64    = 2'd2;
   localparam logic [1:0]  NOISE_RATE_TONE2 = 2'd3;
   localparam logic [3:0]  ATTEN_SILENT     = 4'd15;
   localparam logic [10:0] TONE_COUNT_RESET  = 11'd1024;
   localparam logic [10:0] NOISE_COUNT_RESET = 11'd16;
   localparam logic [10:0] NOISE_RELOAD_0    = 11'h010;
   localparam logic [10:0] NOISE_RELOAD_1    = 11'h020;
   localparam logic [10:0] NOISE_RELOAD_2    = 11'h040;
   localparam logic [15:0] SHIFT_RESET       = 16'h8000;
   localparam logic [15:0] SHIFT_SEED        = 16'h4000;

   // weight = floor(pct * 256 / 100) = (pct * PAN_RECIP) >> 11 for pct <= 100
   localparam logic [12:0] PAN_RECIP   = 13'd5243;
   localparam logic [8:0]  WEIGHT_FULL = 9'd256;
   // floor(y / 100) = (y * PCT_RECIP) >> 29 for y <= 3276800
   localparam logic [22:0] PCT_RECIP   = 23'd5368710;

   typedef struct packed {
      logic [3:0] atten;
      logic       level;
   } psg_chan_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_LEFT,
      ST_RIGHT,
      ST_ACCUM,
      ST_SCALE,
      ST_RECIP,
      ST_ROUND
   } psg_mix_state_type;

   function automatic logic [13:0] atten_mag(input logic [3:0] atten);
      logic [13:0] mag;
      unique case (atten)
         4'd0:    mag = 14'd8192;
         4'd1:    mag = 14'd6508;
         4'd2:    mag = 14'd5172;
         4'd3:    mag = 14'd4108;
         4'd4:    mag = 14'd3264;
         4'd5:    mag = 14'd2592;
         4'd6:    mag = 14'd2060;
         4'd7:    mag = 14'd1636;
         4'd8:    mag = 14'd1300;
         4'd9:    mag = 14'd1032;
         4'd10:   mag = 14'd820;
         4'd11:   mag = 14'd652;
         4'd12:   mag = 14'd516;
         4'd13:   mag = 14'd412;
         4'd14:   mag = 14'd328;
         default: mag = 14'd0;
      endcase
      return mag;
   endfunction

   function automatic logic [6:0] pct_clamp(input logic [6:0] v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

endpackage
`default_nettype wire

FILE: src/psg_tone_noise_generator.sv
// Top level of the sound generator: handshakes, control registers, channels, mixer.
// Depends on psg_pkg, psg_chan and psg_mix.
//
//   channel  ports                                   moves
//   req      req_valid/req_ready, action, data       write, tick or sample transaction
//   rsp      rsp_valid/rsp_ready, left/right sample  one stereo pair per sample transaction
//   csr      csr_wr_en, csr_index, csr_wdata         control register write, no wait
//
// Write and tick transactions leave req_ready high.
// A sample transaction runs through the shared mixer multiplier
// (four steps per channel, three per side) with req_ready low meanwhile.
// The result register holds a pending pair; a finished mix waits on it.
// Synchronous reset restores all channel state and control registers.
`default_nettype none
module psg_tone_noise_generator import psg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_wdata
);

   logic [NUM_CHAN-1:0][6:0]           pan_ff;
   logic [6:0]                         volume_ff;
   psg_chan_status_type [NUM_CHAN-1:0] status;
   logic                               accept;
   logic                               mix_idle;

   assign req_ready = mix_idle;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff[0] <= PAN_TONE0_RESET;
         pan_ff[1] <= PAN_TONE1_RESET;
         pan_ff[2] <= PAN_TONE2_RESET;
         pan_ff[3] <= PAN_NOISE_RESET;
         volume_ff <= VOLUME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAN_TONE0:     pan_ff[0] <= csr_wdata;
            CSR_PAN_TONE1:     pan_ff[1] <= csr_wdata;
            CSR_PAN_TONE2:     pan_ff[2] <= csr_wdata;
            CSR_PAN_NOISE:     pan_ff[3] <= csr_wdata;
            CSR_MASTER_VOLUME: volume_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   psg_chan u_chan (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_action == ACT_WRITE),
      .tick_en (accept && req_action == ACT_TICK),
      .data    (req_data),
      .status  (status)
   );

   psg_mix u_mix (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && req_action == ACT_SAMPLE),
      .pan           (pan_ff),
      .master_volume (volume_ff),
      .status        (status),
      .idle          (mix_idle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left      (rsp_left_sample),
      .rsp_right     (rsp_right_sample)
   );

endmodule
`default_nettype wire

FILE: src/psg_chan.sv
// Tone and noise channel state: command byte decode and per-tick update.
// Depends on psg_pkg and the assertion macro header.
`default_nettype none
`include "psg_tone_noise_generator_macros.svh"
module psg_chan import psg_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic                                tick_en,
   input  logic [7:0]                          data,
   output psg_chan_status_type [NUM_CHAN-1:0]  status
);

   logic [9:0]          tone_period_ff [NUM_TONE];
   logic [9:0]          tone_period_in [NUM_TONE];
   logic [10:0]         tone_count_ff  [NUM_TONE];
   logic [10:0]         tone_count_in  [NUM_TONE];
   logic [NUM_TONE-1:0] tone_level_ff, tone_level_in;
   logic [3:0]          tone_atten_ff  [NUM_TONE];
   logic [3:0]          tone_atten_in  [NUM_TONE];
   logic [3:0]          noise_atten_ff, noise_atten_in;
   logic [1:0]          noise_rate_ff, noise_rate_in;
   logic                noise_white_ff, noise_white_in;
   logic [15:0]         noise_shift_ff, noise_shift_in;
   logic [10:0]         noise_count_ff, noise_count_in;
   logic                noise_level_ff, noise_level_in;
   logic [1:0]          latch_chan_ff, latch_chan_in;
   logic                latch_atten_ff, latch_atten_in;

   always_comb begin
      logic [10:0] tcount;
      logic [10:0] ncount;
      logic [10:0] reload;
      logic [15:0] shifted;
      logic        fb;
      logic [1:0]  ch;

      tone_period_in = tone_period_ff;
      tone_count_in  = tone_count_ff;
      tone_level_in  = tone_level_ff;
      tone_atten_in  = tone_atten_ff;
      noise_atten_in = noise_atten_ff;
      noise_rate_in  = noise_rate_ff;
      noise_white_in = noise_white_ff;
      noise_shift_in = noise_shift_ff;
      noise_count_in = noise_count_ff;
      noise_level_in = noise_level_ff;
      latch_chan_in  = latch_chan_ff;
      latch_atten_in = latch_atten_ff;
      tcount  = '0;
      ncount  = '0;
      reload  = '0;
      shifted = '0;
      fb      = 1'b0;
      ch      = data[6:5];

      if (wr_en) begin
         if (data[7]) begin
            latch_chan_in  = ch;
            latch_atten_in = data[4];
            if (data[4]) begin
               if (ch != NOISE_CHAN) begin
                  tone_atten_in[ch] = data[3:0];
               end else begin
                  noise_atten_in = data[3:0];
               end
            end else if (ch != NOISE_CHAN) begin
               tone_period_in[ch] = {tone_period_ff[ch][9:4], data[3:0]};
            end else begin
               noise_shift_in = SHIFT_SEED;
               noise_rate_in  = data[1:0];
               noise_white_in = data[2];
            end
         end else if (!latch_atten_ff && latch_chan_ff != NOISE_CHAN) begin
            tone_period_in[latch_chan_ff] = {data[5:0], tone_period_ff[latch_chan_ff][3:0]};
         end
      end else if (tick_en) begin
         for (int i = 0; i < NUM_TONE; i++) begin
            if (tone_period_ff[i] < 10'd2) begin
               tone_level_in[i] = 1'b1;
            end else begin
               tcount = tone_count_ff[i] - 11'd1;
               if (tcount == '0) begin
                  tone_count_in[i] = {1'b0, tone_period_ff[i]};
                  tone_level_in[i] = ~tone_level_ff[i];
               end else begin
                  tone_count_in[i] = tcount;
               end
            end
         end
         if (noise_rate_ff == NOISE_RATE_TONE2 && tone_period_ff[NUM_TONE-1] < 10'd2) begin
            noise_level_in = 1'b1;
         end else begin
            unique case (noise_rate_ff)
               NOISE_RATE_16: reload = NOISE_RELOAD_0;
               NOISE_RATE_32: reload = NOISE_RELOAD_1;
               NOISE_RATE_64: reload = NOISE_RELOAD_2;
               default:       reload = {tone_period_ff[NUM_TONE-1], 1'b0};
            endcase
            ncount = noise_count_ff - 11'd1;
            if (ncount == '0) begin
               noise_count_in = reload;
               fb = noise_white_ff ? (noise_shift_ff[0] ^ noise_shift_ff[1])
                                   : noise_shift_ff[0];
               shifted = {1'b0, noise_shift_ff[15] | fb, noise_shift_ff[14:1]};
               if (shifted == '0) begin
                  shifted = 16'd1;
               end
               noise_shift_in = shifted;
               noise_level_in = shifted[0];
            end else begin
               noise_count_in = ncount;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TONE; i++) begin
            tone_period_ff[i] <= '0;
            tone_count_ff[i]  <= TONE_COUNT_RESET;
            tone_atten_ff[i]  <= ATTEN_SILENT;
         end
         tone_level_ff  <= '0;
         noise_atten_ff <= ATTEN_SILENT;
         noise_rate_ff  <= NOISE_RATE_16;
         noise_white_ff <= 1'b0;
         noise_shift_ff <= SHIFT_RESET;
         noise_count_ff <= NOISE_COUNT_RESET;
         noise_level_ff <= 1'b0;
         latch_chan_ff  <= '0;
         latch_atten_ff <= 1'b0;
      end else begin
         tone_period_ff <= tone_period_in;
         tone_count_ff  <= tone_count_in;
         tone_level_ff  <= tone_level_in;
         tone_atten_ff  <= tone_atten_in;
         noise_atten_ff <= noise_atten_in;
         noise_rate_ff  <= noise_rate_in;
         noise_white_ff <= noise_white_in;
         noise_shift_ff <= noise_shift_in;
         noise_count_ff <= noise_count_in;
         noise_level_ff <= noise_level_in;
         latch_chan_ff  <= latch_chan_in;
         latch_atten_ff <= latch_atten_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_TONE; i++) begin
         status[i].atten = tone_atten_ff[i];
         status[i].level = tone_level_ff[i];
      end
      status[NUM_CHAN-1].atten = noise_atten_ff;
      status[NUM_CHAN-1].level = noise_level_ff;
   end

   `PSG_ASSERT(a_shift_nonzero, clock, reset, noise_shift_ff != '0)
   `PSG_ASSERT(a_noise_hold, clock, reset, tick_en && !wr_en && noise_rate_ff == NOISE_RATE_TONE2 && tone_period_ff[NUM_TONE-1] < 10'd2 |=> noise_level_ff)

endmodule
`default_nettype wire

FILE: src/psg_mix.sv
// Stereo mixer: sequencer around one shared multiplier, plus result register.
// Depends on psg_pkg and the assertion macro header.
`default_nettype none
`include "psg_tone_noise_generator_macros.svh"
module psg_mix import psg_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [NUM_CHAN-1:0][6:0]            pan,
   input  logic [6:0]                          master_volume,
   input  psg_chan_status_type [NUM_CHAN-1:0]  status,
   output logic                                idle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_left,
   output logic signed [15:0]                  rsp_right
);

   psg_mix_state_type  state_ff, state_in;
   logic [1:0]         ch_ff;
   logic               side_ff;
   logic [8:0]         w_ff;
   logic signed [16:0] acc_l_ff, acc_r_ff;
   logic               sign_ff;
   logic [15:0]        left_hold_ff;
   logic [44:0]        prod_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_left_ff, rsp_right_ff;

   logic [21:0]        mul_a;
   logic [22:0]        mul_b;
   logic               prod_en;
   logic               out_free;
   logic [13:0]        mag;
   logic [13:0]        part_mag;
   logic signed [16:0] part_s;
   logic signed [16:0] side_sum;
   logic signed [16:0] sat;
   logic [15:0]        clamp_mag;
   logic [15:0]        quot;
   logic [15:0]        result;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mag      = atten_mag(status[ch_ff].atten);
   assign part_mag = status[ch_ff].level ? prod_ff[21:8]
                                         : 14'((prod_ff[21:0] + 22'd255) >> 8);
   assign part_s   = status[ch_ff].level ? $signed({3'b000, part_mag})
                                         : -$signed({3'b000, part_mag});
   assign side_sum = side_ff ? acc_r_ff : acc_l_ff;
   assign quot     = prod_ff[44:29];
   assign result   = sign_ff ? 16'(-quot) : quot;

   always_comb begin
      if (side_sum > 17'sd32767) begin
         sat = 17'sd32767;
      end else if (side_sum < -17'sd32768) begin
         sat = -17'sd32768;
      end else begin
         sat = side_sum;
      end
      clamp_mag = sat[16] ? 16'(-sat) : 16'(sat);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_LEFT;
         ST_LEFT:   state_in = ST_RIGHT;
         ST_RIGHT:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = (ch_ff == NOISE_CHAN) ? ST_SCALE : ST_WEIGHT;
         ST_SCALE:  state_in = ST_RECIP;
         ST_RECIP:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (!side_ff) begin
               state_in = ST_SCALE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      prod_en = 1'b0;
      idle    = 1'b0;
      unique case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_WEIGHT: begin
            mul_a   = 22'(pct_clamp(pan[ch_ff]));
            mul_b   = 23'(PAN_RECIP);
            prod_en = 1'b1;
         end
         ST_LEFT: begin
            mul_a   = 22'(mag);
            mul_b   = 23'(WEIGHT_FULL - prod_ff[19:11]);
            prod_en = 1'b1;
         end
         ST_RIGHT: begin
            mul_a   = 22'(mag);
            mul_b   = 23'(w_ff);
            prod_en = 1'b1;
         end
         ST_SCALE: begin
            mul_a   = 22'(clamp_mag);
            mul_b   = 23'(pct_clamp(master_volume));
            prod_en = 1'b1;
         end
         ST_RECIP: begin
            mul_a   = prod_ff[21:0];
            mul_b   = PCT_RECIP;
            prod_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == ST_IDLE && start) begin
         ch_ff    <= '0;
         side_ff  <= 1'b0;
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end
      if (state_ff == ST_LEFT) begin
         w_ff <= prod_ff[19:11];
      end
      if (state_ff == ST_RIGHT) begin
         acc_l_ff <= acc_l_ff + part_s;
      end
      if (state_ff == ST_ACCUM) begin
         acc_r_ff <= acc_r_ff + part_s;
         ch_ff    <= ch_ff + 2'd1;
      end
      if (state_ff == ST_SCALE) begin
         sign_ff <= sat[16];
      end
      if (state_ff == ST_ROUND && !side_ff) begin
         left_hold_ff <= result;
         side_ff      <= 1'b1;
      end
      if (state_ff == ST_ROUND && side_ff && out_free) begin
         rsp_left_ff  <= left_hold_ff;
         rsp_right_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ROUND && side_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = $signed(rsp_left_ff);
   assign rsp_right = $signed(rsp_right_ff);

   `PSG_ASSERT(a_start_idle, clock, reset, start |-> state_ff == ST_IDLE)
   `PSG_ASSERT(a_acc_range, clock, reset, state_ff == ST_SCALE |-> (acc_l_ff >= -17'sd32768 && acc_l_ff <= 17'sd32768 && acc_r_ff >= -17'sd32768 && acc_r_ff <= 17'sd32768))
   `PSG_ASSERT(a_result_load, clock, reset, state_ff == ST_ROUND && side_ff && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)

endmodule
`default_nettype wire

FILE: test/tb_psg_tone_noise_generator.sv
// Self-checking testbench for psg_tone_noise_generator: a directed table, then random traffic.
// Holds its own model of the tone, noise and mixer state; depends on psg_pkg and the RTL.
`timescale 1ns / 100ps
module tb_psg_tone_noise_generator import psg_pkg::*; ();

   localparam logic [1:0] ACT_NONE       = 2'd3;
   localparam int         MIX_LATENCY    = 22;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         SEGMENTS       = 6;
   localparam int         SEGMENT_ITEMS  = 210;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         DIRECTED_ROWS  = 24;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_type;

   typedef struct packed {
      logic [1:0]         act;
      logic [7:0]         dat;
      logic               fixed;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } test_step_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_TICK;
   logic [7:0]         req_data = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_left_sample;
   logic signed [15:0] rsp_right_sample;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = CSR_PAN_TONE0;
   logic [6:0]         csr_wdata = 7'd0;

   psg_tone_noise_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_sample (rsp_left_sample),
      .rsp_right_sample(rsp_right_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   int gain_lut [16] = '{8192, 6508, 5172, 4108, 3264, 2592, 2060, 1636,
                         1300, 1032, 820, 652, 516, 412, 328, 0};

   logic [9:0]  sq_period [3];
   logic [10:0] sq_count [3];
   logic        sq_level [3];
   logic [3:0]  sq_atten [3];
   logic [3:0]  nz_atten;
   logic [1:0]  nz_rate;
   logic        nz_white;
   logic [15:0] nz_lfsr;
   logic [10:0] nz_count;
   logic        nz_level;
   logic [1:0]  cmd_chan;
   logic        cmd_atten;
   logic [6:0]  reg_csr [5];

   stereo_type pairs_due [$];
   stereo_type pair_seen;
   int      n_errors = 0;
   int      n_items = 0;
   int      n_checked = 0;
   int      quiet_cycles = 0;
   int      snd_idle_pct = 7;
   int      rcv_idle_pct = 88;
   int      hold_request = 0;
   int      hold_left = 0;

   test_step_type directed_steps [DIRECTED_ROWS] = '{
      '{ACT_SAMPLE, 8'h00, 1'b1, 16'sd0,     16'sd0},
      '{ACT_TICK,   8'h00, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h90, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hB0, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hD0, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hF0, 1'b0, 16'sd0,     16'sd0},
      '{ACT_SAMPLE, 8'h00, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hE3, 1'b0, 16'sd0,     16'sd0},
      '{ACT_TICK,   8'h00, 1'b0, 16'sd0,     16'sd0},
      '{ACT_SAMPLE, 8'h00, 1'b1, 16'sd16416, 16'sd16352},
      '{ACT_WRITE,  8'h8F, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h3F, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hA2, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h00, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hC1, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h9F, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h55, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hE4, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'h2A, 1'b0, 16'sd0,     16'sd0},
      '{ACT_NONE,   8'hFF, 1'b0, 16'sd0,     16'sd0},
      '{ACT_TICK,   8'hFF, 1'b0, 16'sd0,     16'sd0},
      '{ACT_SAMPLE, 8'hA5, 1'b0, 16'sd0,     16'sd0},
      '{ACT_WRITE,  8'hFE, 1'b0, 16'sd0,     16'sd0},
      '{ACT_SAMPLE, 8'h5A, 1'b0, 16'sd0,     16'sd0}
   };

   task automatic reset_model();
      int i;
      for (i = 0; i < NUM_TONE; i++) begin
         sq_period[i] = '0;
         sq_count[i]  = TONE_COUNT_RESET;
         sq_level[i]  = 1'b0;
         sq_atten[i]  = ATTEN_SILENT;
      end
      nz_atten  = ATTEN_SILENT;
      nz_rate   = NOISE_RATE_16;
      nz_white  = 1'b0;
      nz_lfsr   = SHIFT_RESET;
      nz_count  = NOISE_COUNT_RESET;
      nz_level  = 1'b0;
      cmd_chan  = 2'd0;
      cmd_atten = 1'b0;
      reg_csr[CSR_PAN_TONE0]     = PAN_TONE0_RESET;
      reg_csr[CSR_PAN_TONE1]     = PAN_TONE1_RESET;
      reg_csr[CSR_PAN_TONE2]     = PAN_TONE2_RESET;
      reg_csr[CSR_PAN_NOISE]     = PAN_NOISE_RESET;
      reg_csr[CSR_MASTER_VOLUME] = VOLUME_RESET;
   endtask

   function automatic int clamp_pct(input logic [6:0] p);
      return (p > PCT_MAX) ? int'(PCT_MAX) : int'(p);
   endfunction

   function automatic void apply_command(input logic [7:0] d);
      if (d[7]) begin
         cmd_chan  = d[6:5];
         cmd_atten = d[4];
         if (cmd_atten) begin
            if (cmd_chan == NOISE_CHAN) nz_atten = d[3:0];
            else sq_atten[cmd_chan] = d[3:0];
         end else if (cmd_chan != NOISE_CHAN) begin
            sq_period[cmd_chan][3:0] = d[3:0];
         end else begin
            nz_lfsr  = SHIFT_SEED;
            nz_rate  = d[1:0];
            nz_white = d[2];
         end
      end else if (!cmd_atten && cmd_chan != NOISE_CHAN) begin
         sq_period[cmd_chan][9:4] = d[5:0];
      end
   endfunction

   function automatic void advance_chip();
      logic [10:0] reload;
      logic        fb;
      int          i;
      for (i = 0; i < NUM_TONE; i++) begin
         if (sq_period[i] < 10'd2) begin
            sq_level[i] = 1'b1;
         end else begin
            sq_count[i] = sq_count[i] - 11'd1;
            if (sq_count[i] == 11'd0) begin
               sq_count[i] = {1'b0, sq_period[i]};
               sq_level[i] = ~sq_level[i];
            end
         end
      end
      if (nz_rate == NOISE_RATE_TONE2 && sq_period[2] < 10'd2) begin
         nz_level = 1'b1;
         return;
      end
      case (nz_rate)
         NOISE_RATE_16: reload = NOISE_RELOAD_0;
         NOISE_RATE_32: reload = NOISE_RELOAD_1;
         NOISE_RATE_64: reload = NOISE_RELOAD_2;
         default:       reload = {sq_period[2], 1'b0};
      endcase
      nz_count = nz_count - 11'd1;
      if (nz_count == 11'd0) begin
         nz_count = reload;
         fb = nz_white ? (nz_lfsr[0] ^ nz_lfsr[1]) : nz_lfsr[0];
         nz_lfsr = (nz_lfsr >> 1) | (16'(fb) << 14);
         if (nz_lfsr == 16'd0) nz_lfsr = 16'd1;
         nz_level = nz_lfsr[0];
      end
   endfunction

   function automatic int voice_share(input logic [3:0] att, input logic lvl,
                                      input logic [6:0] pan, input logic right_side);
      int w;
      int prod;
      if (att == ATTEN_SILENT) return 0;
      w = (clamp_pct(pan) * 256) / 100;
      if (!right_side) w = 256 - w;
      prod = gain_lut[att] * w;
      return lvl ? (prod >> 8) : -((prod + 255) >> 8);
   endfunction

   function automatic logic signed [15:0] scale_side(input int s);
      int mv;
      int v;
      mv = clamp_pct(reg_csr[CSR_MASTER_VOLUME]);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      if (s < 0) v = -(((-s) * mv) / 100);
      else v = (s * mv) / 100;
      return v[15:0];
   endfunction

   function automatic stereo_type mix_pair();
      stereo_type pair;
      int      l;
      int      r;
      int      i;
      l = voice_share(nz_atten, nz_level, reg_csr[CSR_PAN_NOISE], 1'b0);
      r = voice_share(nz_atten, nz_level, reg_csr[CSR_PAN_NOISE], 1'b1);
      for (i = 0; i < NUM_TONE; i++) begin
         l += voice_share(sq_atten[i], sq_level[i], reg_csr[i], 1'b0);
         r += voice_share(sq_atten[i], sq_level[i], reg_csr[i], 1'b1);
      end
      pair.left  = scale_side(l);
      pair.right = scale_side(r);
      return pair;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      n_errors++;
   endtask

   // call at a falling edge; returns at the falling edge after the transaction
   task automatic drive_req(input logic [1:0] act, input logic [7:0] dat,
                            input logic fixed, input stereo_type fixed_pair);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_data   <= dat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (act)
         ACT_WRITE:  apply_command(dat);
         ACT_TICK:   advance_chip();
         ACT_SAMPLE: pairs_due.push_back(fixed ? fixed_pair : mix_pair());
         default:    ;
      endcase
      if (act != ACT_NONE) n_items++;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pairs_due.size() != 0) @(negedge clock);
      repeat (MIX_LATENCY + 8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [6:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      if (idx <= CSR_MASTER_VOLUME) reg_csr[idx] = val;
   endtask

   task automatic configure_segment(input int seg);
      logic [6:0] pan;
      logic [6:0] vol;
      int         i;
      for (i = 0; i < NUM_CHAN; i++) begin
         case (seg)
            1:       pan = 7'd0;
            2:       pan = PCT_MAX;
            3:       pan = 7'd127;
            default: pan = 7'($urandom_range(0, 127));
         endcase
         write_csr(CSR_PAN_TONE0 + 3'(i), pan);
      end
      case (seg)
         1:       vol = PCT_MAX;
         2:       vol = 7'd127;
         3:       vol = 7'd0;
         default: vol = 7'($urandom_range(0, 127));
      endcase
      write_csr(CSR_MASTER_VOLUME, vol);
      write_csr(CSR_MASTER_VOLUME + 3'($urandom_range(1, 3)), 7'($urandom_range(0, 127)));
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pairs_due.size() == 0) begin
            report_mismatch("stereo pair returned with none outstanding");
         end else begin
            pair_seen = pairs_due.pop_front();
            if (rsp_left_sample !== pair_seen.left)
               report_mismatch($sformatf("left got %0d want %0d",
                                         rsp_left_sample, pair_seen.left));
            if (rsp_right_sample !== pair_seen.right)
               report_mismatch($sformatf("right got %0d want %0d",
                                         rsp_right_sample, pair_seen.right));
            n_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int         seg;
      int         sent;
      int         pick;
      int         sel;
      int         i;
      logic [1:0] ch;
      logic [9:0] period;
      stereo_type fixed_pair;
      reset_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         fixed_pair.left  = directed_steps[i].left;
         fixed_pair.right = directed_steps[i].right;
         drive_req(directed_steps[i].act, directed_steps[i].dat,
                   directed_steps[i].fixed, fixed_pair);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         drain_block();
         configure_segment(seg);
         snd_idle_pct = (seg < 2) ? 7 : (seg < 4) ? 88 : 0;
         rcv_idle_pct = (seg < 2) ? 88 : (seg < 4) ? 7 : 0;
         if (seg == 4) hold_request = 1;
         sent = 0;
         while (sent < SEGMENT_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               drive_req(ACT_TICK, 8'($urandom), 1'b0, '0);
               sent++;
            end else if (pick < 85) begin
               drive_req(ACT_SAMPLE, 8'($urandom), 1'b0, '0);
               sent++;
            end else if (pick < 89) begin
               ch  = 2'($urandom_range(0, 2));
               sel = $urandom_range(0, 99);
               if (sel < 70) period = 10'($urandom_range(2, 40));
               else if (sel < 85) period = 10'($urandom_range(0, 1));
               else period = 10'($urandom_range(0, 1023));
               drive_req(ACT_WRITE, {1'b1, ch, 1'b0, period[3:0]}, 1'b0, '0);
               drive_req(ACT_WRITE, {1'b0, 1'($urandom), period[9:4]}, 1'b0, '0);
               sent += 2;
            end else if (pick < 92) begin
               ch = 2'($urandom_range(0, 3));
               drive_req(ACT_WRITE, {1'b1, ch, 1'b1,
                         ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom)}, 1'b0, '0);
               sent++;
            end else if (pick < 94) begin
               for (i = 0; i < NUM_CHAN; i++)
                  drive_req(ACT_WRITE, {1'b1, 2'(i), 1'b1, 4'd0}, 1'b0, '0);
               drive_req(ACT_TICK, 8'($urandom), 1'b0, '0);
               drive_req(ACT_SAMPLE, 8'($urandom), 1'b0, '0);
               sent += NUM_CHAN + 2;
            end else if (pick < 96) begin
               drive_req(ACT_WRITE, {1'b1, NOISE_CHAN, 1'b0, 4'($urandom)}, 1'b0, '0);
               sent++;
            end else if (pick < 99) begin
               drive_req(ACT_WRITE, 8'($urandom), 1'b0, '0);
               sent++;
            end else begin
               drive_req(ACT_NONE, 8'($urandom), 1'b0, '0);
            end
         end
      end

      drain_block();
      $display("Ran %0d write, tick and sample transactions over %0d control settings.",
               n_items, SEGMENTS + 1);
      $display("Compared %0d stereo pairs against the model; %0d mismatches.",
               n_checked, n_errors);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/psg_pkg.sv
src/psg_chan.sv
src/psg_mix.sv
src/psg_tone_noise_generator.sv
test/tb_psg_tone_noise_generator.sv
